### hdl/assert_macros.svh
// Assertion helper macros included by burgers_stencil_update.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent property under clk_i, disabled while reset is low.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every rising edge of clk_i.
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`endif

### hdl/bsu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsu_pkg: shared types and constants
// Register indexes and the control group handed from the sequencer to the
// update cell chain.
// ----------------------------------------------------------------------------
package bsu_pkg;
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_COEFX  = 2'd2;
  localparam logic [1:0] REG_COEFY  = 2'd3;

  typedef enum logic [1:0] {
    NK_COPY_OLD  = 2'd0,
    NK_COPY_LEFT = 2'd1,
    NK_INTERIOR  = 2'd2
  } node_kind_e;

  typedef struct packed {
    node_kind_e kind;
    logic       second;
    logic       done;
    logic [7:0] col;
    logic [7:0] row;
  } node_ctl_t;
endpackage
`default_nettype wire

### hdl/bsu_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsu_cell: one stage of the update chain
// Holds one piece of the update and hands it to the next cell each cycle that en_i is high.
// Stage 0: differences; 1: s = dx*cx + dy*cy; 2: u*s; 3: round, subtract,
// saturate.
// ----------------------------------------------------------------------------
module bsu_cell #(
  parameter int STAGE = 0,
  parameter int SB    = 16
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   en_i,
  input  wire                   vld_i,
  input  wire bsu_pkg::node_ctl_t ctl_i,
  input  wire signed [SB-1:0]   u_i,
  input  wire signed [SB-1:0]   a_i,
  input  wire signed [SB-1:0]   b_i,
  input  wire signed [SB-1:0]   c_i,
  input  wire signed [SB-1:0]   d_i,
  input  wire signed [SB+17:0]  s_i,
  input  wire signed [2*SB+18:0] p_i,
  input  wire [15:0]            cx_i,
  input  wire [15:0]            cy_i,
  output logic                  vld_o,
  output bsu_pkg::node_ctl_t    ctl_o,
  output logic signed [SB-1:0]  u_o,
  output logic signed [SB-1:0]  a_o,
  output logic signed [SB-1:0]  b_o,
  output logic signed [SB+17:0] s_o,
  output logic signed [2*SB+18:0] p_o
);
  import bsu_pkg::*;
  localparam int SH = SB + 12;
  logic signed [SB:0]     dx, dy;
  logic signed [SB+17:0]  s_d;
  logic signed [2*SB+18:0] p_d;
  logic [2*SB+18:0] ap, rq;
  logic signed [SB+2:0] q, res;
  logic signed [SB-1:0] sat;
  logic signed [SB-1:0] a_d, b_d;
  logic vld_q;

  always_comb begin
    dx = $signed({b_i[SB-1], b_i}) - $signed({a_i[SB-1], a_i});
    dy = $signed({d_i[SB-1], d_i}) - $signed({c_i[SB-1], c_i});
    a_d = a_i;
    b_d = b_i;
    if (STAGE == 0) begin
      a_d = dx[SB:1];
      b_d = dy[SB:1];
    end
    s_d = '0;
    p_d = '0;
    q = '0;
    res = '0;
    sat = u_i;
    ap = '0;
    rq = '0;
    if (STAGE == 1) begin
      s_d = $signed({a_i, s_i[0]}) * $signed({1'b0, cx_i})
          + $signed({b_i, s_i[1]}) * $signed({1'b0, cy_i});
    end
    if (STAGE == 2) begin
      p_d = $signed(u_i) * s_i;
    end
    if (STAGE == 3) begin
      ap = p_i[2*SB+18] ? (2*SB+19)'(-p_i) : p_i;
      rq = (ap + ((2*SB+19)'(1) << (SH - 1))) >> SH;
      if (rq > ((2*SB+19)'(1) << (SB + 1))) rq = (2*SB+19)'(1) << (SB + 1);
      q = $signed({1'b0, rq[SB+1:0]});
      res = p_i[2*SB+18] ? $signed({{3{u_i[SB-1]}}, u_i}) + q
                         : $signed({{3{u_i[SB-1]}}, u_i}) - q;
      if (res > $signed({4'b0, {(SB-1){1'b1}}})) sat = {1'b0, {(SB-1){1'b1}}};
      else if (res < $signed({3'b111, 1'b1, {(SB-1){1'b0}}}))
        sat = {1'b1, {(SB-1){1'b0}}};
      else sat = res[SB-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (en_i) vld_q <= vld_i;
  end
  assign vld_o = vld_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_o <= ctl_i;
      u_o   <= (STAGE == 3) ? sat : u_i;
      a_o   <= a_d;
      b_o   <= b_d;
      s_o   <= (STAGE == 0) ? (SB+18)'({dy[0], dx[0]}) : s_d;
      p_o   <= p_d;
    end
  end
endmodule
`default_nettype wire

### hdl/burgers_stencil_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// burgers_stencil_update: one explicit step of 2D inviscid Burgers
// Usage: old samples enter on s_axis in raster order, one item per cycle
// while s_axis_tready is high. Results leave on m_axis with column, row,
// new value and frame_done; they lag one row behind the input. Each item
// passes a line buffer read stage, a chain of four update cells and the
// output register. Throughput is one item per cycle while m_axis is not
// stalled, except in the last row, where one item gives two results and
// the input side takes no new item until the chain and the single result
// port have drained it.
// Reset clears counters and the chain; line buffers are not cleared.
// Registers: 0 grid_width, 1 grid_height, 2 coef_x, 3 coef_y; writing a
// size restarts the frame. When a result waits and m_axis_tready is low the
// whole chain holds and s_axis_tready drops.
// ----------------------------------------------------------------------------
module burgers_stencil_update #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 256,
  parameter int SAMPLE_BITS = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata, // sample_in
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [((SAMPLE_BITS+16+7)/8)*8-1:0] m_axis_tdata, // node_col, node_row, new_value
  output logic       m_axis_tlast,  // frame_done
  input  wire        cfg_we_i,
  input  wire [1:0]  cfg_idx_i,
  input  wire [15:0] cfg_wdata_i
);
  import bsu_pkg::*;
  `include "assert_macros.svh"
  localparam int SB = SAMPLE_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1) > 9 ? $clog2(MAX_WIDTH + 1) : 9;
  localparam int RW = $clog2(MAX_HEIGHT + 1) > 9 ? $clog2(MAX_HEIGHT + 1) : 9;
  localparam int OW = ((SB + 16 + 7) / 8) * 8;

  logic [8:0] gw_q, gh_q;
  logic [15:0] cx_q, cy_q;
  logic [CW-1:0] w, col_q;
  logic [RW-1:0] h, row_q, c_r;
  logic [CW-1:0] c_c;
  logic signed [SB-1:0] prev_mem [MAX_WIDTH];
  logic signed [SB-1:0] older_mem [MAX_WIDTH];
  logic signed [SB-1:0] x;
  logic acc, en, st_bsy, restart;
  logic signed [SB-1:0] last_q;

  // read stage registers
  logic rv_q, wr_q;
  node_ctl_t rc_q;
  logic signed [SB-1:0] prd_q, prr_q, ord_q, lft_q, x0_q;
  logic [AW-1:0] wa_q;

  always_comb begin
    w = (gw_q < 9'd3) ? CW'(3) : (CW'(gw_q) > CW'(MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(gw_q));
    h = (gh_q < 9'd3) ? RW'(3) : (RW'(gh_q) > RW'(MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(gh_q));
    c_c = col_q;
    c_r = row_q;
    if (col_q >= w || row_q >= h) begin
      c_c = '0;
      c_r = '0;
    end
    x = $signed(s_axis_tdata[SB-1:0]);
  end

  // two-result phase of last row: second result taken from chain output
  logic       sec_q;
  logic [SB-1:0] sec_v_q;
  node_ctl_t  sec_c_q;
  logic       ov_q;
  node_ctl_t  oc_q;
  logic signed [SB-1:0] ovl_q;

  logic cv;
  node_ctl_t cc;
  logic signed [SB-1:0] cu, ca0, cb0, ca1, cb1, ca2, cb2, cu0, cu1, cu2;
  logic signed [SB+17:0] cs0, cs1, cs2;
  logic signed [2*SB+18:0] cp0, cp1, cp2;
  logic v0, v1, v2;
  node_ctl_t k0, k1, k2;

  assign en = !ov_q || m_axis_tready;
  assign st_bsy = sec_q || (rv_q && rc_q.second) || (v0 && k0.second)
                || (v1 && k1.second) || (v2 && k2.second) || (cv && cc.second);
  assign s_axis_tready = en && !st_bsy;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign restart = cfg_we_i && (cfg_idx_i == REG_WIDTH || cfg_idx_i == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= 9'd256; gh_q <= 9'd256; cx_q <= '0; cy_q <= '0;
      col_q <= '0; row_q <= '0;
    end else begin
      if (restart) begin
        col_q <= '0;
        row_q <= '0;
      end else if (acc) begin
        if (c_c + CW'(1) == w) begin
          col_q <= '0;
          row_q <= (c_r + RW'(1) == h) ? '0 : c_r + RW'(1);
        end else begin
          col_q <= c_c + CW'(1);
          row_q <= c_r;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WIDTH:  gw_q <= cfg_wdata_i[8:0];
          REG_HEIGHT: gh_q <= cfg_wdata_i[8:0];
          REG_COEFX:  cx_q <= cfg_wdata_i;
          REG_COEFY:  cy_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // line buffers: registered reads of prev at c and c+1 and older at c on
  // accept; write back next cycle; left neighbor is the previous old value
  logic [AW-1:0] ad, adn;
  assign ad  = c_c[AW-1:0];
  assign adn = (ad == AW'(MAX_WIDTH - 1)) ? ad : ad + AW'(1);

  node_ctl_t nc;
  always_comb begin
    nc.col = 8'(c_c);
    nc.row = 8'(c_r - RW'(1));
    nc.second = (c_r == h - RW'(1));
    nc.done = 1'b0;
    if (c_r == RW'(1) || c_c == '0) nc.kind = NK_COPY_OLD;
    else if (c_c == w - CW'(1)) nc.kind = NK_COPY_LEFT;
    else nc.kind = NK_INTERIOR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0; wr_q <= 1'b0;
    end else begin
      wr_q <= acc;
      if (en) rv_q <= acc && (c_r != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      rc_q  <= nc;
      x0_q  <= x;
      wa_q  <= ad;
      lft_q <= prd_q;
      prd_q <= prev_mem[ad];
      prr_q <= prev_mem[adn];
      ord_q <= older_mem[ad];
    end
    if (wr_q) begin
      older_mem[wa_q] <= prd_q;
      prev_mem[wa_q]  <= x0_q;
    end
  end

  bsu_cell #(.STAGE(0), .SB(SB)) u_c0 (.clk_i, .rst_ni, .en_i(en), .vld_i(rv_q),
    .ctl_i(rc_q), .u_i(prd_q), .a_i(lft_q), .b_i(prr_q), .c_i(ord_q), .d_i(x0_q),
    .s_i('0), .p_i('0), .cx_i(cx_q), .cy_i(cy_q), .vld_o(v0), .ctl_o(k0), .u_o(cu0),
    .a_o(ca0), .b_o(cb0), .s_o(cs0), .p_o(cp0));
  bsu_cell #(.STAGE(1), .SB(SB)) u_c1 (.clk_i, .rst_ni, .en_i(en), .vld_i(v0),
    .ctl_i(k0), .u_i(cu0), .a_i(ca0), .b_i(cb0), .c_i(x0_q), .d_i(x0_q),
    .s_i(cs0), .p_i(cp0), .cx_i(cx_q), .cy_i(cy_q), .vld_o(v1), .ctl_o(k1), .u_o(cu1),
    .a_o(ca1), .b_o(cb1), .s_o(cs1), .p_o(cp1));
  bsu_cell #(.STAGE(2), .SB(SB)) u_c2 (.clk_i, .rst_ni, .en_i(en), .vld_i(v1),
    .ctl_i(k1), .u_i(cu1), .a_i(ca1), .b_i(cb1), .c_i(x0_q), .d_i(x0_q),
    .s_i(cs1), .p_i(cp1), .cx_i(cx_q), .cy_i(cy_q), .vld_o(v2), .ctl_o(k2), .u_o(cu2),
    .a_o(ca2), .b_o(cb2), .s_o(cs2), .p_o(cp2));
  bsu_cell #(.STAGE(3), .SB(SB)) u_c3 (.clk_i, .rst_ni, .en_i(en), .vld_i(v2),
    .ctl_i(k2), .u_i(cu2), .a_i(ca2), .b_i(cb2), .c_i(x0_q), .d_i(x0_q),
    .s_i(cs2), .p_i(cp2), .cx_i(cx_q), .cy_i(cy_q), .vld_o(cv), .ctl_o(cc), .u_o(cu),
    .a_o(), .b_o(), .s_o(), .p_o());

  // old value and down sample travel alongside: interior uses cu, or the old
  // value if coefs are zero; copy-old uses it, copy-left the prior interior value
  logic signed [SB-1:0] oldv_q [4];
  logic signed [SB-1:0] dnv_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      oldv_q[0] <= prd_q; dnv_q[0] <= x0_q;
      for (int i = 1; i < 4; i++) begin
        oldv_q[i] <= oldv_q[i-1]; dnv_q[i] <= dnv_q[i-1];
      end
    end
  end

  logic signed [SB-1:0] v_sel;
  always_comb begin
    case (cc.kind)
      NK_INTERIOR:  v_sel = ((cx_q == '0 && cy_q == '0)) ? oldv_q[3] : cu;
      NK_COPY_LEFT: v_sel = last_q;
      default:      v_sel = oldv_q[3];
    endcase
  end

  node_ctl_t fc, sc;
  always_comb begin
    fc = cc;
    fc.done = 1'b0;
    sc = cc;
    sc.row = cc.row + 8'd1;
    sc.second = 1'b0;
    sc.done = (CW'(cc.col) == w - CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0; sec_q <= 1'b0; last_q <= '0;
    end else if (en) begin
      ov_q <= cv || sec_q;
      sec_q <= 1'b0;
      if (sec_q) begin
        oc_q <= sec_c_q; ovl_q <= sec_v_q;
      end else if (cv) begin
        oc_q <= fc; ovl_q <= v_sel;
        if (cc.kind == NK_INTERIOR) last_q <= v_sel;
        if (cc.second) begin
          sec_q <= 1'b1;
          sec_c_q <= sc;
          sec_v_q <= (cc.col == 8'd0) ? dnv_q[3] : v_sel;
        end
      end
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = OW'({ovl_q, oc_q.row, oc_q.col});
  assign m_axis_tlast  = oc_q.done;

  `ASSERT_IMPL(a_hold, m_axis_tvalid && !m_axis_tready, s_axis_tready == 1'b0,
               "input taken while output stalled")
  `ASSERT_IMPL(a_sec, sec_q, !s_axis_tready, "input taken during second result")
  `ASSERT_PROP(a_pos, col_q <= CW'(MAX_WIDTH), "column counter out of range")
endmodule
`default_nettype wire
